FILE: rtl/dgv_pkg.sv
// Shared constants, codes and control types for the density gradient velocity block.
`default_nettype none
package dgv_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 11;
  localparam int DATA_W     = 16;
  localparam int DIV_STEPS  = 8;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int ADDR_W     = 4;
  localparam int OUT_DATA_W = 56;

  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MIN_CENTER = 2'd2;

  localparam logic [DIM_W-1:0] MAP_WIDTH_RESET  = DIM_W'(1024);
  localparam logic [DIM_W-1:0] MAP_HEIGHT_RESET = DIM_W'(1024);
  localparam logic [DATA_W-1:0] MIN_CENTER_RESET = DATA_W'(2);

  typedef enum logic [1:0] {
    SEL_CELL,
    SEL_ROW_END,
    SEL_LAST_ROW
  } emit_sel_t;

  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [DATA_W-1:0] min_center;
    logic              restart;
  } cfg_t;

  typedef struct packed {
    logic      accept;
    logic      load;
    logic      div_init;
    logic      init_y;
    logic      div_step;
    logic      div_store;
    logic      store_y;
    logic      out_load;
    emit_sel_t out_sel;
  } dgv_cmd_t;

  typedef struct packed {
    logic emit_cell;
    logic emit_row_end;
    logic emit_last_row;
    logic div_en;
    logic div_last;
    logic out_free;
  } dgv_status_t;

endpackage
`default_nettype wire

FILE: rtl/dgv_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dgv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/dgv_regs.sv
// APB configuration registers with clamped map geometry.
`default_nettype none
module dgv_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [dgv_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output dgv_pkg::cfg_t                   cfg
);

  logic [dgv_pkg::DIM_W-1:0]  map_width;
  logic [dgv_pkg::DIM_W-1:0]  map_height;
  logic [dgv_pkg::DATA_W-1:0] min_center;
  logic                       restart;
  logic                       wr;
  logic [1:0]                 idx;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign idx     = paddr[3:2];
  // geometry write clears the frame counters at the same edge
  assign restart = wr && ((idx == dgv_pkg::REG_MAP_WIDTH) ||
                          (idx == dgv_pkg::REG_MAP_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= dgv_pkg::MAP_WIDTH_RESET;
      map_height <= dgv_pkg::MAP_HEIGHT_RESET;
      min_center <= dgv_pkg::MIN_CENTER_RESET;
    end else begin
      if (wr) begin
        case (idx)
          dgv_pkg::REG_MAP_WIDTH: begin
            map_width <= pwdata[dgv_pkg::DIM_W-1:0];
          end
          dgv_pkg::REG_MAP_HEIGHT: begin
            map_height <= pwdata[dgv_pkg::DIM_W-1:0];
          end
          dgv_pkg::REG_MIN_CENTER: begin
            min_center <= pwdata[dgv_pkg::DATA_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      dgv_pkg::REG_MAP_WIDTH:  prdata = 32'(map_width);
      dgv_pkg::REG_MAP_HEIGHT: prdata = 32'(map_height);
      dgv_pkg::REG_MIN_CENTER: prdata = 32'(min_center);
      default:                 prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (map_width == '0) begin
      cfg.width = dgv_pkg::DIM_W'(1);
    end else if (map_width > dgv_pkg::DIM_W'(dgv_pkg::MAX_WIDTH)) begin
      cfg.width = dgv_pkg::DIM_W'(dgv_pkg::MAX_WIDTH);
    end else begin
      cfg.width = map_width;
    end
    if (map_height == '0) begin
      cfg.height = dgv_pkg::DIM_W'(1);
    end else if (map_height > dgv_pkg::DIM_W'(dgv_pkg::MAX_HEIGHT)) begin
      cfg.height = dgv_pkg::DIM_W'(dgv_pkg::MAX_HEIGHT);
    end else begin
      cfg.height = map_height;
    end
    cfg.min_center = min_center;
    cfg.restart    = restart;
  end

endmodule
`default_nettype wire

FILE: rtl/dgv_ctrl.sv
// Controller state machine: sequences load, shared divider and result emission.
`default_nettype none
module dgv_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire dgv_pkg::dgv_status_t status,
  output dgv_pkg::dgv_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DINIT,
    ST_DIV,
    ST_DFIN,
    ST_EMIT0,
    ST_EMIT1,
    ST_EMIT2
  } state_t;

  state_t state;
  state_t state_next;
  logic   sel_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel_y <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DINIT) begin
        sel_y <= 1'b0;
      end else if (state == ST_DFIN) begin
        sel_y <= 1'b1;
      end
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.out_sel   = dgv_pkg::SEL_CELL;
    s_tready      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_DINIT;
      end
      ST_DINIT: begin
        if (status.div_en) begin
          cmd.div_init = 1'b1;
          state_next   = ST_DIV;
        end else begin
          state_next = ST_EMIT0;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_DFIN;
        end
      end
      ST_DFIN: begin
        cmd.div_store = 1'b1;
        cmd.store_y   = sel_y;
        if (!sel_y) begin
          cmd.div_init = 1'b1;
          cmd.init_y   = 1'b1;
          state_next   = ST_DIV;
        end else begin
          state_next = ST_EMIT0;
        end
      end
      ST_EMIT0: begin
        cmd.out_sel = dgv_pkg::SEL_CELL;
        if (!status.emit_cell) begin
          state_next = ST_EMIT1;
        end else if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_EMIT1;
        end
      end
      ST_EMIT1: begin
        cmd.out_sel = dgv_pkg::SEL_ROW_END;
        if (!status.emit_row_end) begin
          state_next = ST_EMIT2;
        end else if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_EMIT2;
        end
      end
      ST_EMIT2: begin
        cmd.out_sel = dgv_pkg::SEL_LAST_ROW;
        if (!status.emit_last_row) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/dgv_datapath.sv
// Datapath: line buffers, window, counters, shared radix-4 divider and output register.
`default_nettype none
module dgv_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire dgv_pkg::cfg_t                  cfg,
  input  wire dgv_pkg::dgv_cmd_t              cmd,
  output dgv_pkg::dgv_status_t                status,
  input  wire logic [dgv_pkg::DATA_W-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [dgv_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                                m_tlast
);

  localparam int DW = dgv_pkg::DATA_W;
  localparam int CW = dgv_pkg::COL_W;
  localparam int RW = dgv_pkg::ROW_W;
  localparam int NW = dgv_pkg::DIM_W;

  // frame state
  logic [CW-1:0] col_cnt;
  logic [RW-1:0] row_cnt;
  logic [DW-1:0] prev_in;
  logic [DW-1:0] win_left;
  logic [DW-1:0] win_center;
  logic [DW-1:0] win_down;
  logic [DW-1:0] din;

  // per-item captured values
  logic [CW-1:0] cur_x;
  logic [RW-1:0] cur_y;
  logic          emit_cell;
  logic          emit_row_end;
  logic          emit_last_row;
  logic          div_en;
  logic [DW-1:0] mag_x;
  logic [DW-1:0] mag_y;
  logic          neg_x;
  logic          neg_y;
  logic [DW-1:0] den;
  logic [DW-1:0] vel_x;
  logic [DW-1:0] vel_y;

  // divider
  logic [DW-1:0]                 rem;
  logic [DW-1:0]                 sh;
  logic [DW-1:0]                 quo;
  logic                          sat;
  logic                          neg;
  logic [dgv_pkg::STEP_W-1:0]    step_cnt;
  logic [DW-1:0]                 rem_next;
  logic [DW-1:0]                 sh_next;
  logic [DW-1:0]                 quo_next;
  logic [DW-1:0]                 div_result;

  // line buffers
  logic [DW-1:0] r1;
  logic [DW-1:0] r2;

  // load-cycle logic
  logic [NW-1:0] x_ext;
  logic [NW-1:0] y_ext;
  logic [NW-1:0] x_plus;
  logic [NW-1:0] y_plus;
  logic          interior;
  logic [DW:0]   num_x;
  logic [DW:0]   num_y;
  logic [DW:0]   abs_x;
  logic [DW:0]   abs_y;
  logic [DW-1:0] init_mag;

  dgv_ram #(.WIDTH(DW), .DEPTH(dgv_pkg::MAX_WIDTH)) u_row1 (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (col_cnt),
    .wdata (din),
    .raddr (col_cnt),
    .rdata (r1)
  );

  dgv_ram #(.WIDTH(DW), .DEPTH(dgv_pkg::MAX_WIDTH)) u_row2 (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (col_cnt),
    .wdata (r1),
    .raddr (col_cnt),
    .rdata (r2)
  );

  assign x_ext    = NW'(col_cnt);
  assign y_ext    = NW'(row_cnt);
  assign x_plus   = x_ext + NW'(1);
  assign y_plus   = y_ext + NW'(1);
  assign interior = (x_ext >= NW'(2)) && (y_ext >= NW'(2)) &&
                    (x_plus <= cfg.width) && (y_plus <= cfg.height);
  assign num_x    = {1'b0, win_left} - {1'b0, r1};
  assign num_y    = {1'b0, win_down} - {1'b0, prev_in};
  assign abs_x    = num_x[DW] ? (~num_x + (DW+1)'(1)) : num_x;
  assign abs_y    = num_y[DW] ? (~num_y + (DW+1)'(1)) : num_y;
  assign init_mag = cmd.init_y ? mag_y : mag_x;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      din <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      col_cnt    <= '0;
      row_cnt    <= '0;
      prev_in    <= '0;
      win_left   <= '0;
      win_center <= '0;
      win_down   <= '0;
    end else if (cmd.load) begin
      win_left   <= win_center;
      win_center <= r1;
      win_down   <= r2;
      prev_in    <= din;
      if (x_plus >= cfg.width) begin
        col_cnt <= '0;
        row_cnt <= (y_plus >= cfg.height) ? '0 : y_plus[RW-1:0];
      end else begin
        col_cnt <= x_plus[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_cell     <= 1'b0;
      emit_row_end  <= 1'b0;
      emit_last_row <= 1'b0;
      div_en        <= 1'b0;
    end else if (cmd.load) begin
      emit_cell     <= (col_cnt != '0) && (row_cnt != '0);
      emit_row_end  <= (x_plus == cfg.width) && (row_cnt != '0);
      emit_last_row <= (y_plus == cfg.height);
      div_en        <= (col_cnt != '0) && (row_cnt != '0) && interior &&
                       (win_center > cfg.min_center);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x <= col_cnt;
      cur_y <= row_cnt;
      mag_x <= abs_x[DW-1:0];
      mag_y <= abs_y[DW-1:0];
      neg_x <= num_x[DW];
      neg_y <= num_y[DW];
      den   <= win_center;
    end
  end

  // two restoring steps per cycle on (mag << 7) / den
  always_comb begin
    logic [DW:0] t;
    logic [DW:0] d;
    rem_next = rem;
    sh_next  = sh;
    quo_next = quo;
    for (int i = 0; i < 2; i++) begin
      t = {rem_next, sh_next[DW-1]};
      d = t - {1'b0, den};
      if (t >= {1'b0, den}) begin
        rem_next = d[DW-1:0];
        quo_next = {quo_next[DW-2:0], 1'b1};
      end else begin
        rem_next = t[DW-1:0];
        quo_next = {quo_next[DW-2:0], 1'b0};
      end
      sh_next = {sh_next[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem      <= DW'(init_mag[DW-1:9]);
      sh       <= {init_mag[8:0], 7'b0};
      quo      <= '0;
      sat      <= DW'(init_mag[DW-1:8]) >= den;
      neg      <= cmd.init_y ? neg_y : neg_x;
      step_cnt <= '0;
    end else if (cmd.div_step) begin
      rem      <= rem_next;
      sh       <= sh_next;
      quo      <= quo_next;
      step_cnt <= step_cnt + dgv_pkg::STEP_W'(1);
    end
  end

  always_comb begin
    if (sat) begin
      div_result = neg ? 16'h8000 : 16'h7fff;
    end else begin
      div_result = neg ? (~quo + DW'(1)) : quo;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vel_x <= '0;
      vel_y <= '0;
    end else if (cmd.div_store) begin
      if (cmd.store_y) begin
        vel_y <= div_result;
      end else begin
        vel_x <= div_result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_sel)
        dgv_pkg::SEL_CELL: begin
          m_tdata <= {4'b0, RW'(cur_y - RW'(1)), CW'(cur_x - CW'(1)), vel_y, vel_x};
          m_tlast <= !emit_row_end && !emit_last_row;
        end
        dgv_pkg::SEL_ROW_END: begin
          m_tdata <= {4'b0, RW'(cur_y - RW'(1)), CW'(cfg.width - NW'(1)), 32'b0};
          m_tlast <= !emit_last_row;
        end
        dgv_pkg::SEL_LAST_ROW: begin
          m_tdata <= {4'b0, cur_y, cur_x, 32'b0};
          m_tlast <= 1'b1;
        end
        default: begin
          m_tdata <= '0;
          m_tlast <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    status.emit_cell     = emit_cell;
    status.emit_row_end  = emit_row_end;
    status.emit_last_row = emit_last_row;
    status.div_en        = div_en;
    status.div_last      = step_cnt == dgv_pkg::STEP_W'(dgv_pkg::DIV_STEPS - 1);
    status.out_free      = !m_tvalid || m_tready;
  end

endmodule
`default_nettype wire

FILE: rtl/density_gradient_velocity.sv
// Top level of the density gradient velocity block.
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   s_tdata: density
//  m_*       out  m_tvalid/m_tready   m_tdata: velocity_x, velocity_y, column, row; m_tlast
//  apb       in   psel/penable        map_width @0, map_height @4, min_center_density @8
//
// One cell at a time: accept, load, divider setup and three emit slots. When the centre
// cell is interior and above threshold, the shared divider first forms each velocity
// (two quotient bits per cycle: eight steps and a store per quotient).
// rst is synchronous; line buffers are not cleared. A geometry write restarts the frame.
// A result waiting on m_tready stalls emission; the next cell may be taken while the
// last result waits.
`default_nettype none
module density_gradient_velocity (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [dgv_pkg::DATA_W-1:0]          s_tdata,   // [15:0] density
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // [15:0] velocity_x, [31:16] velocity_y, [41:32] column, [51:42] row
  output logic      [dgv_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                     m_tlast,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [dgv_pkg::ADDR_W-1:0]          paddr,
  input  wire logic [31:0]                         pwdata,
  output logic      [31:0]                         prdata,
  output logic                                     pready
);

  dgv_pkg::cfg_t        cfg;
  dgv_pkg::dgv_cmd_t    cmd;
  dgv_pkg::dgv_status_t status;

  dgv_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dgv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dgv_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire
